/* hw/rtl/blr_pkg.sv */
// Shared constants and the coordinate clamp for the line rasterizer.
// No dependencies; the core imports everything from here.
`timescale 1ns / 1ps

package blr_pkg;

   // Coordinate width; the image may be up to 2**COORD_BITS pixels on a side.
   localparam int COORD_BITS = 12;
   // Fixed widths of the request endpoints, the color and the size registers.
   localparam int IN_BITS    = 16;
   localparam int COLOR_BITS = 8;
   localparam int SIZE_BITS  = 13;
   // Doubled deltas and the signed error term.
   localparam int TWICE_BITS = COORD_BITS + 2;
   localparam int ERR_BITS   = COORD_BITS + 3;
   // Wide enough to compare a size register against the coordinate cap.
   localparam int LIM_BITS   = (SIZE_BITS > COORD_BITS + 1) ? SIZE_BITS : COORD_BITS + 1;

   localparam int  CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd480;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Step directions, two-bit two's complement.
   localparam logic [1:0] DIR_ZERO = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;
   localparam logic [1:0] DIR_NEG  = 2'b11;

   // Clamps a signed endpoint coordinate into [0, size-1]. A size of zero acts
   // as one, and a size above the coordinate range acts as the full range.
   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic signed [IN_BITS-1:0] c,
      input logic [SIZE_BITS-1:0]      size
   );
      logic [LIM_BITS-1:0]   size_wide;
      logic [COORD_BITS-1:0] top;
      logic [IN_BITS-1:0]    top_wide;
      logic [COORD_BITS-1:0] res;
      size_wide = LIM_BITS'(size);
      if (size == '0) begin
         top = '0;
      end else if (size_wide > (LIM_BITS'(1) << COORD_BITS)) begin
         top = '1;
      end else begin
         top = COORD_BITS'(size_wide - LIM_BITS'(1));
      end
      top_wide = IN_BITS'(top);
      if (c[IN_BITS-1]) begin
         res = '0;
      end else if ($unsigned(c) > top_wide) begin
         res = top;
      end else begin
         res = c[COORD_BITS-1:0];
      end
      return res;
   endfunction

endpackage

/* hw/rtl/bresenham_line_rasterizer_core.sv */
// Bresenham line rasterizer core: start and step requests in, one pixel out.
// Depends on blr_pkg for widths, register indexes, command codes and clamping.
`timescale 1ns / 1ps

//  channel | direction | handshake            | contents
//  req_    | in        | req_valid/req_ready  | command, two endpoints, color
//  rsp_    | out       | rsp_valid/rsp_ready  | pixel x/y, color, valid, last flag
//  csr_    | in        | csr_valid/csr_ready  | register index, write data
//
// One request per cycle. A request is first held in the input register and is
// then processed into the response register, where its response stays valid
// until it is taken.
// The line state (position, error, deltas) updates in the single step between
// those registers: a step subtracts and adds into the error and increments the position.
// Reset is synchronous; it clears the line state and sets the size registers to 640x480.
// A stalled response holds the input register; requests stall only when both
// registers are full and the response is not taken in that cycle.

module bresenham_line_rasterizer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic signed [blr_pkg::IN_BITS-1:0] req_start_x,
   input  logic signed [blr_pkg::IN_BITS-1:0] req_start_y,
   input  logic signed [blr_pkg::IN_BITS-1:0] req_end_x,
   input  logic signed [blr_pkg::IN_BITS-1:0] req_end_y,
   input  logic [blr_pkg::COLOR_BITS-1:0]    req_color,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [blr_pkg::COORD_BITS-1:0]    rsp_pixel_x,
   output logic [blr_pkg::COORD_BITS-1:0]    rsp_pixel_y,
   output logic [blr_pkg::COLOR_BITS-1:0]    rsp_pixel_color,
   output logic                              rsp_pixel_valid,
   output logic                              rsp_last_pixel,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [blr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [blr_pkg::SIZE_BITS-1:0]     csr_data
);
   import blr_pkg::*;

   // Size registers.
   logic [SIZE_BITS-1:0] width_ff, height_ff;

   // Input register.
   logic                       in_valid_ff;
   logic                       in_cmd_ff;
   logic signed [IN_BITS-1:0]  in_sx_ff, in_sy_ff, in_ex_ff, in_ey_ff;
   logic [COLOR_BITS-1:0]      in_color_ff;

   // Line state.
   logic [COORD_BITS-1:0]      cur_x_ff, cur_y_ff, goal_x_ff, goal_y_ff;
   logic [COORD_BITS-1:0]      cur_x_in, cur_y_in, goal_x_in, goal_y_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic [TWICE_BITS-1:0]      twice_dx_ff, twice_dy_ff, twice_dx_in, twice_dy_in;
   logic [1:0]                 dir_x_ff, dir_y_ff, dir_x_in, dir_y_in;
   logic                       x_major_ff, x_major_in;
   logic                       busy_ff, busy_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;

   // Response register.
   logic                       rsp_valid_ff;
   logic [COORD_BITS-1:0]      rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;
   logic [COLOR_BITS-1:0]      rsp_color_ff, rsp_color_in;
   logic                       rsp_pv_ff, rsp_pv_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Work signals.
   logic                       out_free, proc;
   logic [COORD_BITS-1:0]      x1, y1, x2, y2;
   logic signed [COORD_BITS:0] diff_x, diff_y;
   logic [COORD_BITS-1:0]      abs_x, abs_y;
   logic [TWICE_BITS-1:0]      tdx, tdy;
   logic                       s_major, minor_step, major_pos;
   logic signed [ERR_BITS-1:0] err_sel;
   logic [TWICE_BITS-1:0]      twice_major, twice_minor;
   logic [COORD_BITS-1:0]      nx, ny;
   logic                       step_x, step_y;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;

   // Start setup: clamp both endpoints and derive deltas and directions.
   assign x1 = clamp_coord(in_sx_ff, width_ff);
   assign y1 = clamp_coord(in_sy_ff, height_ff);
   assign x2 = clamp_coord(in_ex_ff, width_ff);
   assign y2 = clamp_coord(in_ey_ff, height_ff);

   assign diff_x  = $signed({1'b0, x2}) - $signed({1'b0, x1});
   assign diff_y  = $signed({1'b0, y2}) - $signed({1'b0, y1});
   assign abs_x   = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
   assign abs_y   = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
   assign tdx     = {1'b0, abs_x, 1'b0};
   assign tdy     = {1'b0, abs_y, 1'b0};
   assign s_major = abs_x >= abs_y;

   // Step: the minor axis moves on a positive error, or on zero error when the
   // major direction is positive.
   assign major_pos   = x_major_ff ? (dir_x_ff == DIR_POS) : (dir_y_ff == DIR_POS);
   assign minor_step  = (err_ff > 0) || ((err_ff == '0) && major_pos);
   assign twice_major = x_major_ff ? twice_dx_ff : twice_dy_ff;
   assign twice_minor = x_major_ff ? twice_dy_ff : twice_dx_ff;
   assign err_sel     = minor_step ? err_ff - $signed({1'b0, twice_major}) : err_ff;
   assign step_x      = x_major_ff || minor_step;
   assign step_y      = !x_major_ff || minor_step;
   assign nx = step_x ? cur_x_ff + {{(COORD_BITS-2){dir_x_ff[1]}}, dir_x_ff} : cur_x_ff;
   assign ny = step_y ? cur_y_ff + {{(COORD_BITS-2){dir_y_ff[1]}}, dir_y_ff} : cur_y_ff;

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      err_in       = err_ff;
      twice_dx_in  = twice_dx_ff;
      twice_dy_in  = twice_dy_ff;
      dir_x_in     = dir_x_ff;
      dir_y_in     = dir_y_ff;
      x_major_in   = x_major_ff;
      busy_in      = busy_ff;
      color_in     = color_ff;
      rsp_x_in     = '0;
      rsp_y_in     = '0;
      rsp_color_in = '0;
      rsp_pv_in    = 1'b0;
      rsp_last_in  = 1'b0;
      if (in_cmd_ff == CMD_START) begin
         cur_x_in    = x1;
         cur_y_in    = y1;
         goal_x_in   = x2;
         goal_y_in   = y2;
         twice_dx_in = tdx;
         twice_dy_in = tdy;
         dir_x_in    = diff_x[COORD_BITS] ? DIR_NEG : (diff_x == '0 ? DIR_ZERO : DIR_POS);
         dir_y_in    = diff_y[COORD_BITS] ? DIR_NEG : (diff_y == '0 ? DIR_ZERO : DIR_POS);
         x_major_in  = s_major;
         err_in      = s_major ? $signed({1'b0, tdy}) - $signed({3'b000, abs_x})
                               : $signed({1'b0, tdx}) - $signed({3'b000, abs_y});
         busy_in     = s_major ? (x1 != x2) : (y1 != y2);
         color_in    = in_color_ff;
         rsp_x_in     = x1;
         rsp_y_in     = y1;
         rsp_color_in = in_color_ff;
         rsp_pv_in    = 1'b1;
         rsp_last_in  = !busy_in;
      end else if (busy_ff) begin
         cur_x_in     = nx;
         cur_y_in     = ny;
         err_in       = err_sel + $signed({1'b0, twice_minor});
         busy_in      = x_major_ff ? (nx != goal_x_ff) : (ny != goal_y_ff);
         rsp_x_in     = nx;
         rsp_y_in     = ny;
         rsp_color_in = color_ff;
         rsp_pv_in    = 1'b1;
         rsp_last_in  = !busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff   <= req_cmd;
         in_sx_ff    <= req_start_x;
         in_sy_ff    <= req_start_y;
         in_ex_ff    <= req_end_x;
         in_ey_ff    <= req_end_y;
         in_color_ff <= req_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff    <= '0;
         cur_y_ff    <= '0;
         goal_x_ff   <= '0;
         goal_y_ff   <= '0;
         err_ff      <= '0;
         twice_dx_ff <= '0;
         twice_dy_ff <= '0;
         dir_x_ff    <= DIR_ZERO;
         dir_y_ff    <= DIR_ZERO;
         x_major_ff  <= 1'b0;
         busy_ff     <= 1'b0;
         color_ff    <= '0;
      end else if (proc) begin
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         goal_x_ff   <= goal_x_in;
         goal_y_ff   <= goal_y_in;
         err_ff      <= err_in;
         twice_dx_ff <= twice_dx_in;
         twice_dy_ff <= twice_dy_in;
         dir_x_ff    <= dir_x_in;
         dir_y_ff    <= dir_y_in;
         x_major_ff  <= x_major_in;
         busy_ff     <= busy_in;
         color_ff    <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_color_ff <= rsp_color_in;
         rsp_pv_ff    <= rsp_pv_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_pixel_valid = rsp_pv_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   // A request waiting on a full response register must stay in place.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("stalled request dropped from the input register");

   // Emitting the last pixel of a line ends the line.
   assert property (@(posedge clock) disable iff (reset)
      proc && rsp_pv_in && rsp_last_in |=> !busy_ff)
      else $error("line still active after its last pixel");

   // A step with no active line reports an empty pixel, with zero coordinates and no last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pv_ff |-> rsp_x_ff == '0 && rsp_y_ff == '0 && !rsp_last_ff)
      else $error("empty response carries pixel data");

   // Stepping only happens while a line is active.
   assert property (@(posedge clock) disable iff (reset)
      proc && in_cmd_ff == CMD_STEP && !busy_ff |=> $stable(cur_x_ff) && $stable(cur_y_ff))
      else $error("idle step moved the current pixel");

endmodule
